// ----- rtl/cdll_pkg.sv -----
// package: types, constants and codes shared by the linked list block
package cdll_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int NODE_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int SIZE_W     = 9;
  localparam int MODE_W     = 4;
  localparam int BYTE_W     = 8;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [MODE_W-1:0] {
    M_INS_FRONT  = 4'd0,
    M_INS_BACK   = 4'd1,
    M_INS_BEFORE = 4'd2,
    M_INS_AFTER  = 4'd3,
    M_DEL_FRONT  = 4'd4,
    M_DEL_BACK   = 4'd5,
    M_DEL_BEFORE = 4'd6,
    M_DEL_AFTER  = 4'd7,
    M_FIRST      = 4'd8,
    M_LAST       = 4'd9,
    M_NEXT       = 4'd10,
    M_PREV       = 4'd11,
    M_READ       = 4'd12
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NOP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK2,
    S_UNLINK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic  en;
    node_t addr;
    node_t data;
  } link_wr_t;

  typedef struct packed {
    logic  en;
    node_t addr;
    byte_t data;
  } byte_wr_t;

endpackage

// ----- rtl/cdll_ram.sv -----
// generic single write, single registered read memory
module cdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cdll_ctrl.sv -----
// sequencer: list pointers, free node allocation, link updates and result register
module cdll_ctrl
  import cdll_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  byte_t             data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output byte_t             cursor_byte,
  output logic [SIZE_W-1:0] list_size,
  output logic [1:0]        status,
  output byte_wr_t          nb_wr,
  output node_t             nb_raddr,
  input  byte_t             nb_rdata,
  output link_wr_t          nx_wr,
  output link_wr_t          pv_wr,
  output node_t             lk_raddr,
  input  node_t             nx_rdata,
  input  node_t             pv_rdata,
  output link_wr_t          fs_wr,
  output node_t             fs_raddr,
  input  node_t             fs_rdata
);

  state_t  state, state_next;
  mode_t   op, op_next;
  byte_t   op_byte, op_byte_next;
  node_t   head, head_next;
  node_t   tail, tail_next;
  node_t   cursor, cursor_next;
  cnt_t    count, count_next;
  cnt_t    free_count, free_count_next;
  cnt_t    fresh, fresh_next;
  node_t   new_node, new_node_next;
  node_t   aux, aux_next;
  node_t   victim, victim_next;
  status_t op_status, op_status_next;
  logic    fwd_hit;
  byte_t   fwd_byte;
  logic    do_unlink;
  node_t   un_node, un_prev, un_succ;
  node_t   ins_node;
  logic    out_load;
  byte_t   fin_byte;

  assign in_stall = (state != S_IDLE);
  assign ins_node = (free_count != '0) ? fs_rdata : fresh[NODE_W-1:0];
  assign fs_raddr = NODE_W'(free_count - 1'b1);
  assign nb_raddr = cursor_next;
  assign fin_byte = (count == '0) ? '0 : (fwd_hit ? fwd_byte : nb_rdata);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      cursor     <= '0;
      count      <= '0;
      free_count <= '0;
      fresh      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      cursor     <= cursor_next;
      count      <= count_next;
      free_count <= free_count_next;
      fresh      <= fresh_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    op_byte   <= op_byte_next;
    new_node  <= new_node_next;
    aux       <= aux_next;
    victim    <= victim_next;
    op_status <= op_status_next;
    fwd_hit   <= nb_wr.en && (nb_wr.addr == cursor_next);
    fwd_byte  <= nb_wr.data;
    if (out_load) begin
      cursor_byte <= fin_byte;
      list_size   <= SIZE_W'(count);
      status      <= op_status;
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    op_byte_next    = op_byte;
    head_next       = head;
    tail_next       = tail;
    cursor_next     = cursor;
    count_next      = count;
    free_count_next = free_count;
    fresh_next      = fresh;
    new_node_next   = new_node;
    aux_next        = aux;
    victim_next     = victim;
    op_status_next  = op_status;
    nb_wr           = '0;
    nx_wr           = '0;
    pv_wr           = '0;
    fs_wr           = '0;
    lk_raddr        = cursor;
    do_unlink       = 1'b0;
    un_node         = victim;
    un_prev         = pv_rdata;
    un_succ         = nx_rdata;

    unique case (state)
      S_IDLE: begin
        if (mode_t'(mode) == M_DEL_FRONT) begin
          lk_raddr = head;
        end else if (mode_t'(mode) == M_DEL_BACK) begin
          lk_raddr = tail;
        end
        if (in_valid) begin
          op_next      = mode_t'(mode);
          op_byte_next = data_byte;
          state_next   = S_EXEC;
        end
      end

      S_EXEC: begin
        op_status_next = ST_DONE;
        state_next     = S_FIN;
        if (op <= M_INS_AFTER) begin
          if (count == CNT_W'(POOL_DEPTH)) begin
            op_status_next = ST_FULL;
          end else begin
            new_node_next = ins_node;
            if (free_count != '0) begin
              free_count_next = free_count - 1'b1;
            end else begin
              fresh_next = fresh + 1'b1;
            end
            nb_wr      = '{en: 1'b1, addr: ins_node, data: op_byte};
            count_next = count + 1'b1;
            if (count == '0) begin
              head_next   = ins_node;
              tail_next   = ins_node;
              cursor_next = ins_node;
            end else begin
              unique case (op)
                M_INS_FRONT: begin
                  nx_wr     = '{en: 1'b1, addr: ins_node, data: head};
                  pv_wr     = '{en: 1'b1, addr: head, data: ins_node};
                  head_next = ins_node;
                end
                M_INS_BACK: begin
                  pv_wr     = '{en: 1'b1, addr: ins_node, data: tail};
                  nx_wr     = '{en: 1'b1, addr: tail, data: ins_node};
                  tail_next = ins_node;
                end
                M_INS_BEFORE: begin
                  nx_wr = '{en: 1'b1, addr: ins_node, data: cursor};
                  if (cursor == head) begin
                    head_next = ins_node;
                    pv_wr     = '{en: 1'b1, addr: cursor, data: ins_node};
                  end else begin
                    pv_wr      = '{en: 1'b1, addr: ins_node, data: pv_rdata};
                    aux_next   = pv_rdata;
                    state_next = S_LINK2;
                  end
                end
                default: begin
                  pv_wr = '{en: 1'b1, addr: ins_node, data: cursor};
                  if (cursor == tail) begin
                    tail_next = ins_node;
                    nx_wr     = '{en: 1'b1, addr: cursor, data: ins_node};
                  end else begin
                    nx_wr      = '{en: 1'b1, addr: ins_node, data: nx_rdata};
                    aux_next   = nx_rdata;
                    state_next = S_LINK2;
                  end
                end
              endcase
            end
          end
        end else if (count == '0) begin
          op_status_next = ST_NOP;
        end else begin
          unique case (op)
            M_DEL_FRONT: begin
              do_unlink = 1'b1;
              un_node   = head;
            end
            M_DEL_BACK: begin
              do_unlink = 1'b1;
              un_node   = tail;
            end
            M_DEL_BEFORE: begin
              if (cursor == head) begin
                op_status_next = ST_NOP;
              end else begin
                victim_next = pv_rdata;
                lk_raddr    = pv_rdata;
                state_next  = S_UNLINK;
              end
            end
            M_DEL_AFTER: begin
              if (cursor == tail) begin
                op_status_next = ST_NOP;
              end else begin
                victim_next = nx_rdata;
                lk_raddr    = nx_rdata;
                state_next  = S_UNLINK;
              end
            end
            M_FIRST: cursor_next = head;
            M_LAST:  cursor_next = tail;
            M_NEXT: begin
              if (cursor == tail) begin
                op_status_next = ST_NOP;
              end else begin
                cursor_next = nx_rdata;
              end
            end
            M_PREV: begin
              if (cursor == head) begin
                op_status_next = ST_NOP;
              end else begin
                cursor_next = pv_rdata;
              end
            end
            default: begin
              // read and unused codes leave the list alone
            end
          endcase
        end
      end

      S_LINK2: begin
        if (op == M_INS_BEFORE) begin
          nx_wr = '{en: 1'b1, addr: aux, data: new_node};
          pv_wr = '{en: 1'b1, addr: cursor, data: new_node};
        end else begin
          pv_wr = '{en: 1'b1, addr: aux, data: new_node};
          nx_wr = '{en: 1'b1, addr: cursor, data: new_node};
        end
        state_next = S_FIN;
      end

      S_UNLINK: begin
        do_unlink = 1'b1;
        un_node   = victim;
      end

      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_unlink) begin
      fs_wr           = '{en: 1'b1, addr: free_count[NODE_W-1:0], data: un_node};
      free_count_next = free_count + 1'b1;
      count_next      = count - 1'b1;
      state_next      = S_FIN;
      if (count == CNT_W'(1)) begin
        head_next   = '0;
        tail_next   = '0;
        cursor_next = '0;
      end else if (un_node == head) begin
        head_next = un_succ;
        if (cursor == un_node) begin
          cursor_next = un_succ;
        end
      end else if (un_node == tail) begin
        tail_next = un_prev;
        if (cursor == un_node) begin
          cursor_next = un_prev;
        end
      end else begin
        nx_wr = '{en: 1'b1, addr: un_prev, data: un_succ};
        pv_wr = '{en: 1'b1, addr: un_succ, data: un_prev};
      end
    end
  end

endmodule

// ----- rtl/cursor_doubly_linked_list_top.sv -----
// top level: cursor linked list with byte, link and free stack memories
// one item at a time; moves, reads, end inserts and end deletes go from the execute
// state straight to the result state; inserts inside the list pass a second link
// write state, and delete before or after the cursor an unlink state fed by the link
// memory read; new input is taken only after the result is loaded, later while stalled
// reset clears pointers, counts and handshake state; memories are not cleared
module cursor_doubly_linked_list_top
  import cdll_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] cursor_byte,
  output logic [SIZE_W-1:0] list_size,
  output logic [1:0]        status
);

  byte_wr_t nb_wr;
  link_wr_t nx_wr, pv_wr, fs_wr;
  node_t    nb_raddr, lk_raddr, fs_raddr;
  byte_t    nb_rdata;
  node_t    nx_rdata, pv_rdata, fs_rdata;

  cdll_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_byte (cursor_byte),
    .list_size   (list_size),
    .status      (status),
    .nb_wr       (nb_wr),
    .nb_raddr    (nb_raddr),
    .nb_rdata    (nb_rdata),
    .nx_wr       (nx_wr),
    .pv_wr       (pv_wr),
    .lk_raddr    (lk_raddr),
    .nx_rdata    (nx_rdata),
    .pv_rdata    (pv_rdata),
    .fs_wr       (fs_wr),
    .fs_raddr    (fs_raddr),
    .fs_rdata    (fs_rdata)
  );

  cdll_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_DEPTH)) u_node_bytes (
    .clk   (clk),
    .we    (nb_wr.en),
    .waddr (nb_wr.addr),
    .wdata (nb_wr.data),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  cdll_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_next_links (
    .clk   (clk),
    .we    (nx_wr.en),
    .waddr (nx_wr.addr),
    .wdata (nx_wr.data),
    .raddr (lk_raddr),
    .rdata (nx_rdata)
  );

  cdll_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_prev_links (
    .clk   (clk),
    .we    (pv_wr.en),
    .waddr (pv_wr.addr),
    .wdata (pv_wr.data),
    .raddr (lk_raddr),
    .rdata (pv_rdata)
  );

  cdll_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_free_stack (
    .clk   (clk),
    .we    (fs_wr.en),
    .waddr (fs_wr.addr),
    .wdata (fs_wr.data),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

endmodule

// ----- rtl/cdll_checker.sv -----
// port checker for the linked list top level, attached by bind
module cdll_checker
  import cdll_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [MODE_W-1:0] mode,
  input logic [BYTE_W-1:0] data_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] cursor_byte,
  input logic [SIZE_W-1:0] list_size,
  input logic [1:0]        status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_byte) && $stable(list_size)
      && $stable(status))
    else $error("result changed while stalled");

  // one item in flight
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // empty list shows zero byte
  a_empty_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (list_size == '0) |-> (cursor_byte == '0))
    else $error("nonzero byte on empty list");

  // full reject only at pool size
  a_full_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (list_size == SIZE_W'(POOL_DEPTH)))
    else $error("full status below pool size");

  // size never exceeds the pool and status never takes the unused code 3
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_size <= SIZE_W'(POOL_DEPTH)) && (status != 2'd3))
    else $error("size or status out of range");

endmodule

bind cursor_doubly_linked_list_top cdll_checker u_cdll_checker (.*);
